// ===== hdl/uvs_pkg.sv =====
// Package with shared constants and types of the UV sphere vertex generator.
package uvs_pkg;

	localparam int INDEX_BITS_DEF = 8;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int CORDIC_ITERS   = 16;
	localparam int RADIUS_BITS    = 16;
	localparam int POS_BITS       = 17;
	localparam int CFG_IDX_BITS   = 2;
	localparam int CFG_DATA_BITS  = 17;
	localparam int ANG_BITS       = 32;
	localparam int TRIG_BITS      = 32;
	localparam int PROD_BITS      = 64;

	localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS      = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_RING_STEP   = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_SECTOR_STEP = 2'd2;

	localparam logic signed [TRIG_BITS-1:0] ONE_Q30  = 32'sd1073741824;
	localparam logic signed [TRIG_BITS-1:0] GAIN_Q30 = 32'sd652032874;
	localparam logic signed [PROD_BITS-1:0] HALF_Q30 = 64'sd536870912;
	localparam int POS_LIMIT = 65535;

	typedef logic signed [TRIG_BITS-1:0] trig_t;

	function automatic logic [ANG_BITS-1:0] atan_turn(input int i);
		logic [ANG_BITS-1:0] r;
		r = '0;
		unique case (i)
			0: r = 32'd536870912;
			1: r = 32'd316933406;
			2: r = 32'd167458908;
			3: r = 32'd85004756;
			4: r = 32'd42667331;
			5: r = 32'd21354465;
			6: r = 32'd10679838;
			7: r = 32'd5340245;
			8: r = 32'd2670163;
			9: r = 32'd1335087;
			10: r = 32'd667544;
			11: r = 32'd333772;
			12: r = 32'd166886;
			13: r = 32'd83443;
			14: r = 32'd41722;
			15: r = 32'd20861;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Q1.30 product rounded to nearest, ties up.
	function automatic trig_t mul_q30(input trig_t a, input trig_t b);
		logic signed [PROD_BITS-1:0] p;
		p = (PROD_BITS'(a) * PROD_BITS'(b)) + HALF_Q30;
		return trig_t'(p >>> 30);
	endfunction

	function automatic logic signed [POS_BITS-1:0] scale_pos(input trig_t f,
		input logic [RADIUS_BITS-1:0] r);
		logic signed [PROD_BITS-1:0] p;
		logic signed [PROD_BITS-1:0] v;
		p = PROD_BITS'(f) * $signed({{(PROD_BITS-RADIUS_BITS){1'b0}}, r});
		v = (p + HALF_Q30) >>> 30;
		if (v > PROD_BITS'(POS_LIMIT)) v = PROD_BITS'(POS_LIMIT);
		else if (v < -PROD_BITS'(POS_LIMIT)) v = -PROD_BITS'(POS_LIMIT);
		return v[POS_BITS-1:0];
	endfunction

endpackage

// ===== hdl/uv_sphere_vertex_generator.sv =====
// Top level of the UV sphere vertex generator.
// Usage: write radius (index 0), ring_step (1) and sector_step (2) through
// cfg_we, cfg_index and cfg_data while idle. Raise start with ring_index and
// sector_index; a request is taken at each edge where start is high and busy
// is low. busy is always low, so one request is taken every cycle.
// Each result appears on pos_x, pos_y, pos_z, tex_u and tex_v for one cycle
// with done high. It passes through the index multiply stage, the quadrant
// stage, the sixteen CORDIC steps, the clamp and fold stage, the sin/cos
// product stage and the radius scaling stage, one register each.
// Results keep request order. The receiver cannot stall; results are not
// held. Reset clears the valid bits of all stages and loads the registers
// with radius 256 and both steps 1.0.
module uv_sphere_vertex_generator #(
	parameter int INDEX_BITS = uvs_pkg::INDEX_BITS_DEF,
	parameter int FRAC_BITS  = uvs_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [INDEX_BITS-1:0]               ring_index,
	input  logic [INDEX_BITS-1:0]               sector_index,
	input  logic                                cfg_we,
	input  logic [uvs_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [FRAC_BITS:0]                  cfg_data,
	output logic                                done,
	output logic signed [uvs_pkg::POS_BITS-1:0] pos_x,
	output logic signed [uvs_pkg::POS_BITS-1:0] pos_y,
	output logic signed [uvs_pkg::POS_BITS-1:0] pos_z,
	output logic [FRAC_BITS:0]                  tex_u,
	output logic [FRAC_BITS:0]                  tex_v
);
	import uvs_pkg::*;

	localparam int FW = FRAC_BITS + 1;
	localparam int PW = INDEX_BITS + FW;
	localparam int N  = CORDIC_ITERS;
	localparam logic [PW-1:0] ONE_FRAC = PW'(1) << FRAC_BITS;

	logic [RADIUS_BITS-1:0] radius_q;
	logic [FW-1:0] ring_step_q, sector_step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q      <= RADIUS_BITS'(256);
			ring_step_q   <= FW'(1) << FRAC_BITS;
			sector_step_q <= FW'(1) << FRAC_BITS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RADIUS:      radius_q      <= cfg_data[RADIUS_BITS-1:0];
				REG_RING_STEP:   ring_step_q   <= cfg_data;
				REG_SECTOR_STEP: sector_step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;
	logic accept;
	assign accept = start && !busy;

	// Stage 1: fractions.
	logic vld_s1;
	logic [PW-1:0] fr_s1, fs_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= accept;
	end
	always_ff @(posedge clk) begin
		fr_s1 <= PW'(ring_index) * PW'(ring_step_q);
		fs_s1 <= PW'(sector_index) * PW'(sector_step_q);
	end

	// Stage 2: phases, quadrant split, CORDIC seed.
	logic [ANG_BITS-1:0] th_ph, ph_ph;
	logic [ANG_BITS+PW-1:0] th_w, ph_w;
	always_comb begin
		th_w = (ANG_BITS+PW)'(fr_s1) << (31 - FRAC_BITS);
		ph_w = (ANG_BITS+PW)'(fs_s1) << (32 - FRAC_BITS);
		th_ph = th_w[ANG_BITS-1:0];
		ph_ph = ph_w[ANG_BITS-1:0];
	end

	trig_t x_c [N+1][2];
	trig_t y_c [N+1][2];
	logic signed [31:0] z_c [N+1][2];
	logic vld_c [N+1];
	logic [1:0] quad_p [N+1][2];
	logic [FW-1:0] tu_p [N+1], tv_p [N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_c[0] <= 1'b0;
		else vld_c[0] <= vld_s1;
	end
	always_ff @(posedge clk) begin
		x_c[0][0] <= GAIN_Q30; x_c[0][1] <= GAIN_Q30;
		y_c[0][0] <= '0;       y_c[0][1] <= '0;
		z_c[0][0] <= $signed({2'b00, th_ph[29:0]});
		z_c[0][1] <= $signed({2'b00, ph_ph[29:0]});
		quad_p[0][0] <= th_ph[31:30];
		quad_p[0][1] <= ph_ph[31:30];
		tv_p[0] <= (fr_s1 > ONE_FRAC) ? ONE_FRAC[FW-1:0] : fr_s1[FW-1:0];
		tu_p[0] <= (fs_s1 > ONE_FRAC) ? ONE_FRAC[FW-1:0] : fs_s1[FW-1:0];
	end

	for (genvar i = 0; i < N; i++) begin : g_cordic
		uvs_cordic_stage #(.SHIFT(i)) u_stage (
			.clk(clk), .arst_n(arst_n), .vld_in(vld_c[i]),
			.x_in(x_c[i]), .y_in(y_c[i]), .z_in(z_c[i]),
			.vld_out(vld_c[i+1]),
			.x_out(x_c[i+1]), .y_out(y_c[i+1]), .z_out(z_c[i+1])
		);
		always_ff @(posedge clk) begin
			quad_p[i+1] <= quad_p[i];
			tu_p[i+1]   <= tu_p[i];
			tv_p[i+1]   <= tv_p[i];
		end
	end

	// Clamp and quadrant fold.
	function automatic trig_t clampq(input trig_t v);
		if (v > ONE_Q30) return ONE_Q30;
		if (v < -ONE_Q30) return -ONE_Q30;
		return v;
	endfunction

	logic vld_f;
	trig_t sn_f [2], cs_f [2];
	logic [FW-1:0] tu_f, tv_f;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_f <= 1'b0;
		else vld_f <= vld_c[N];
	end
	always_ff @(posedge clk) begin
		for (int k = 0; k < 2; k++) begin
			trig_t c, s;
			c = clampq(x_c[N][k]);
			s = clampq(y_c[N][k]);
			unique case (quad_p[N][k])
				2'd0: begin cs_f[k] <= c;  sn_f[k] <= s;  end
				2'd1: begin cs_f[k] <= -s; sn_f[k] <= c;  end
				2'd2: begin cs_f[k] <= -c; sn_f[k] <= -s; end
				default: begin cs_f[k] <= s; sn_f[k] <= -c; end
			endcase
		end
		tu_f <= tu_p[N];
		tv_f <= tv_p[N];
	end

	// Products with sin(theta), and y from -cos(theta).
	logic vld_m;
	trig_t fx_m, fy_m, fz_m;
	logic [FW-1:0] tu_m, tv_m;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_m <= 1'b0;
		else vld_m <= vld_f;
	end
	always_ff @(posedge clk) begin
		fx_m <= mul_q30(cs_f[1], sn_f[0]);
		fz_m <= mul_q30(sn_f[1], sn_f[0]);
		fy_m <= -cs_f[0];
		tu_m <= tu_f;
		tv_m <= tv_f;
	end

	// Radius scaling into the output registers.
	logic done_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= vld_m;
	end
	always_ff @(posedge clk) begin
		pos_x <= scale_pos(fx_m, radius_q);
		pos_y <= scale_pos(fy_m, radius_q);
		pos_z <= scale_pos(fz_m, radius_q);
		tex_u <= tu_m;
		tex_v <= tv_m;
	end
	assign done = done_q;
endmodule

// ===== hdl/uvs_cordic_stage.sv =====
// One registered CORDIC rotation step for a pair of angles.
module uvs_cordic_stage #(
	parameter int SHIFT = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     vld_in,
	input  uvs_pkg::trig_t           x_in [2],
	input  uvs_pkg::trig_t           y_in [2],
	input  logic signed [31:0]       z_in [2],
	output logic                     vld_out,
	output uvs_pkg::trig_t           x_out [2],
	output uvs_pkg::trig_t           y_out [2],
	output logic signed [31:0]       z_out [2]
);
	import uvs_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 2; k++) begin
			if (z_in[k] >= 0) begin
				x_out[k] <= x_in[k] - (y_in[k] >>> SHIFT);
				y_out[k] <= y_in[k] + (x_in[k] >>> SHIFT);
				z_out[k] <= z_in[k] - $signed(atan_turn(SHIFT));
			end else begin
				x_out[k] <= x_in[k] + (y_in[k] >>> SHIFT);
				y_out[k] <= y_in[k] - (x_in[k] >>> SHIFT);
				z_out[k] <= z_in[k] + $signed(atan_turn(SHIFT));
			end
		end
	end
endmodule

// ===== hdl/uvs_checker.sv =====
// Port checker for the UV sphere vertex generator, bound to the top level.
module uvs_checker #(
	parameter int FRAC_BITS = uvs_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic signed [16:0] pos_x,
	input logic signed [16:0] pos_y,
	input logic [FRAC_BITS:0] tex_u,
	input logic [FRAC_BITS:0] tex_v
);
	localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_tex_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (tex_u <= ONE && tex_v <= ONE)) else $error("tex above one");
	a_pos_lim: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (pos_x != -17'sd65536 && pos_y != -17'sd65536))
		else $error("position beyond limit");
	a_no_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##21 !done) else $error("result without request");
endmodule

bind uv_sphere_vertex_generator uvs_checker #(.FRAC_BITS(FRAC_BITS)) u_uvs_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.pos_x(pos_x), .pos_y(pos_y), .tex_u(tex_u), .tex_v(tex_v)
);

// ===== verif/tb_uv_sphere_vertex_generator.sv =====
// Testbench of the UV sphere vertex generator: directed and random grid points checked against a CORDIC predictor.
module tb_uv_sphere_vertex_generator;
	timeunit 1ns;
	timeprecision 1ps;

	import uvs_pkg::*;

	localparam int IDX_W = INDEX_BITS_DEF;
	localparam int FRAC_W = FRAC_BITS_DEF;
	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
	localparam logic [FRAC_W:0] STEP_ONE = (FRAC_W+1)'(1) << FRAC_W;
	localparam int SETTLE_CYCLES = 40;
	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_PHASES = 7;
	localparam int POINTS_PER_PHASE = 200;

	typedef struct {
		logic signed [POS_BITS-1:0] x;
		logic signed [POS_BITS-1:0] y;
		logic signed [POS_BITS-1:0] z;
		logic [FRAC_W:0] u;
		logic [FRAC_W:0] v;
	} vertex_t;

	class vertex_scoreboard;
		logic [RADIUS_BITS-1:0] radius;
		logic [FRAC_W:0] ring_step;
		logic [FRAC_W:0] sector_step;
		vertex_t pending[$];
		int mismatches;
		int checked;
		longint turn_atan[CORDIC_ITERS];

		function new();
			turn_atan = '{536870912, 316933406, 167458908, 85004756, 42667331, 21354465,
				10679838, 5340245, 2670163, 1335087, 667544, 333772,
				166886, 83443, 41722, 20861};
			radius = 16'd256;
			ring_step = STEP_ONE;
			sector_step = STEP_ONE;
		endfunction

		function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [FRAC_W:0] data);
			case (idx)
				REG_RADIUS: radius = data[RADIUS_BITS-1:0];
				REG_RING_STEP: ring_step = data;
				REG_SECTOR_STEP: sector_step = data;
				default: ;
			endcase
		endfunction

		function longint clip(longint val, longint lim);
			if (val > lim) return lim;
			if (val < -lim) return -lim;
			return val;
		endfunction

		function longint round_q30(longint a, longint b);
			return (a * b + 64'sd536870912) >>> 30;
		endfunction

		function logic signed [POS_BITS-1:0] to_position(longint f);
			longint val;
			val = clip((f * longint'(radius) + 64'sd536870912) >>> 30, 65535);
			return val[POS_BITS-1:0];
		endfunction

		// Rotation mode CORDIC on the first quadrant, then fold by the top two phase bits.
		function void sin_cos(logic [ANG_BITS-1:0] phase, output longint sn, output longint cs);
			longint x, y, z, dx, dy, c, s;
			x = 652032874;
			y = 0;
			z = longint'(phase & 32'h3FFF_FFFF);
			for (int i = 0; i < CORDIC_ITERS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx;
					y += dy;
					z -= turn_atan[i];
				end else begin
					x += dx;
					y -= dy;
					z += turn_atan[i];
				end
			end
			c = clip(x, 64'sd1073741824);
			s = clip(y, 64'sd1073741824);
			case (phase[31:30])
				2'd0: begin cs = c; sn = s; end
				2'd1: begin cs = -s; sn = c; end
				2'd2: begin cs = -c; sn = -s; end
				default: begin cs = s; sn = -c; end
			endcase
		endfunction

		function void note_request(logic [IDX_W-1:0] ring, logic [IDX_W-1:0] sector);
			longint fr, fs, st, ct, sp, cp;
			logic [63:0] th, ph;
			vertex_t e;
			fr = longint'(ring) * longint'(ring_step);
			fs = longint'(sector) * longint'(sector_step);
			th = fr << (31 - FRAC_W);
			ph = fs << (32 - FRAC_W);
			sin_cos(th[31:0], st, ct);
			sin_cos(ph[31:0], sp, cp);
			e.x = to_position(round_q30(cp, st));
			e.y = to_position(-ct);
			e.z = to_position(round_q30(sp, st));
			e.u = (fs > STEP_ONE) ? STEP_ONE : fs[FRAC_W:0];
			e.v = (fr > STEP_ONE) ? STEP_ONE : fr[FRAC_W:0];
			pending = {pending, e};
		endfunction

		task report(string msg);
			mismatches++;
			$display("MISMATCH %0t: %s", $realtime, msg);
		endtask

		task check_result(vertex_t got);
			vertex_t e;
			if (pending.size() == 0) begin
				report("vertex arrived with no request outstanding");
				return;
			end
			e = pending.pop_front();
			checked++;
			if (got.x !== e.x) report($sformatf("pos_x %0d, expected %0d", got.x, e.x));
			if (got.y !== e.y) report($sformatf("pos_y %0d, expected %0d", got.y, e.y));
			if (got.z !== e.z) report($sformatf("pos_z %0d, expected %0d", got.z, e.z));
			if (got.u !== e.u) report($sformatf("tex_u %0d, expected %0d", got.u, e.u));
			if (got.v !== e.v) report($sformatf("tex_v %0d, expected %0d", got.v, e.v));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [IDX_W-1:0] ring_index;
	logic [IDX_W-1:0] sector_index;
	logic cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [FRAC_W:0] cfg_data;
	logic done;
	logic signed [POS_BITS-1:0] pos_x, pos_y, pos_z;
	logic [FRAC_W:0] tex_u, tex_v;

	vertex_scoreboard sb;
	int requests_taken;
	int idle_cycles;
	int configs_written;

	uv_sphere_vertex_generator u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.ring_index(ring_index), .sector_index(sector_index),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.tex_u(tex_u), .tex_v(tex_v)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Requests and results are sampled with the values that stood before the edge.
	always @(posedge clk) begin
		vertex_t got;
		bit active;
		if (arst_n && sb != null) begin
			active = 1'b0;
			if (start && !busy) begin
				sb.note_request(ring_index, sector_index);
				requests_taken++;
				active = 1'b1;
			end
			if (done) begin
				got.x = pos_x;
				got.y = pos_y;
				got.z = pos_z;
				got.u = tex_u;
				got.v = tex_v;
				sb.check_result(got);
				active = 1'b1;
			end
			idle_cycles <= active ? 0 : idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no activity for %0d cycles", IDLE_LIMIT);
				$display("uv_sphere_vertex_generator test failed");
				$finish;
			end
		end
	end

	task automatic idle_gap();
		int pick;
		int n;
		pick = $urandom_range(99);
		if (pick < 65) n = 0;
		else if (pick < 93) n = $urandom_range(1, 3);
		else n = $urandom_range(8, 40);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_point(logic [IDX_W-1:0] ring, logic [IDX_W-1:0] sector, bit gaps);
		start <= 1'b1;
		ring_index <= ring;
		sector_index <= sector;
		@(posedge clk iff !busy);
		if (gaps) idle_gap();
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [FRAC_W:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
		configs_written++;
	endtask

	task automatic load_config(logic [FRAC_W:0] rad, logic [FRAC_W:0] rs, logic [FRAC_W:0] ss);
		drain();
		write_reg(REG_RADIUS, rad);
		write_reg(REG_RING_STEP, rs);
		write_reg(REG_UNUSED, (FRAC_W+1)'($urandom));
		write_reg(REG_SECTOR_STEP, ss);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly grid points of a real mesh for the current steps, some anywhere in range.
	task automatic random_points(int count, int rings, int sectors);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(9) < 7)
				send_point(IDX_W'($urandom_range(rings - 1)),
					IDX_W'($urandom_range(sectors - 1)), 1'b1);
			else
				send_point(IDX_W'($urandom), IDX_W'($urandom), 1'b1);
		end
	endtask

	initial begin
		int rings, sectors;
		arst_n = 1'b0;
		start = 1'b0;
		ring_index = '0;
		sector_index = '0;
		cfg_we = 1'b0;
		cfg_index = REG_RADIUS;
		cfg_data = '0;
		requests_taken = 0;
		idle_cycles = 0;
		configs_written = 0;
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values: radius 256, steps of one, so fractions run past one and wrap.
		send_point(0, 0, 1'b0);
		send_point(1, 1, 1'b0);
		send_point(2, 0, 1'b0);
		send_point(255, 255, 1'b0);
		send_point(0, 255, 1'b0);
		send_point(255, 0, 1'b0);

		// Largest radius, zero ring step: every point at the south pole.
		load_config(17'h1FFFF, 0, STEP_ONE);
		send_point(255, 255, 1'b0);
		send_point(0, 1, 1'b0);
		send_point(170, 3, 1'b0);

		// Zero radius, zero sector step.
		load_config(0, STEP_ONE, 0);
		send_point(1, 255, 1'b0);
		send_point(255, 85, 1'b0);

		// A 9 by 17 grid with the largest radius, corners and poles included.
		load_config(65535, STEP_ONE / 8, STEP_ONE / 16);
		send_point(0, 0, 1'b0);
		send_point(8, 16, 1'b0);
		send_point(4, 4, 1'b0);
		send_point(4, 8, 1'b0);
		send_point(2, 12, 1'b0);
		send_point(9, 17, 1'b0);
		send_point(255, 255, 1'b0);
		send_point(170, 85, 1'b0);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			rings = $urandom_range(2, 256);
			sectors = $urandom_range(2, 256);
			if (p == 0) load_config(17'h00100, STEP_ONE, STEP_ONE);
			else if ($urandom_range(3) == 0)
				load_config((FRAC_W+1)'($urandom), (FRAC_W+1)'($urandom_range(STEP_ONE)),
					(FRAC_W+1)'($urandom_range(STEP_ONE)));
			else
				load_config((FRAC_W+1)'($urandom), (FRAC_W+1)'(STEP_ONE / (rings - 1)),
					(FRAC_W+1)'(STEP_ONE / (sectors - 1)));
			random_points(POINTS_PER_PHASE, rings, sectors);
		end

		drain();
		$display("Covered %0d vertex requests over %0d register writes, %0d results checked.",
			requests_taken, configs_written, sb.checked);
		if (sb.mismatches == 0)
			$display("uv_sphere_vertex_generator test passed");
		else
			$display("uv_sphere_vertex_generator test failed");
		$finish;
	end

endmodule
